// ----- rtl/jhs_pkg.sv -----
// shared constants and codes for the jacobi heat stencil solver
`timescale 1ns / 1ps
`default_nettype none

package jhs_pkg;

  localparam int DEF_ROWS = 64;
  localparam int DEF_COLS = 64;

  localparam int VAL_W = 24;
  localparam int CMD_W = 2;
  localparam int POS_W = 6;
  localparam int SUM_W = VAL_W + 2;
  localparam int WORD_W = VAL_W + 1;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic REG_EPSILON = 1'b0;
  localparam logic REG_MAX_ITER = 1'b1;

  localparam logic [VAL_W-1:0] EPSILON_RESET = 24'd6554;
  localparam logic [VAL_W-1:0] MAX_ITER_RESET = 24'd1048576;
  localparam logic [VAL_W-1:0] COUNT_SAT = 24'hFFFFFF;

endpackage

`default_nettype wire

// ----- rtl/jhs_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module jhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/jacobi_heat_stencil_solver.sv -----
// jacobi solver top level: grid store, stencil sequencer and result register
// write and unused items: result the cycle after accept, one item a cycle unless out_ready stalls; read: via ST_READ
// solve: each sweep takes every cell through the self, e, w, s, n, new and diff phases
//   on one ram read port, then a copy pass; ST_CHECK registers the result or resweeps
// after reset the grid is cleared, one cell a cycle; no items then
// reset is synchronous; config registers return to defaults
`timescale 1ns / 1ps
`default_nettype none

module jacobi_heat_stencil_solver
  import jhs_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire logic [CMD_W-1:0] cmd,
  input  wire logic [POS_W-1:0] row,
  input  wire logic [POS_W-1:0] col,
  input  wire logic [VAL_W-1:0] temperature,
  input  wire logic             fixed,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      logic [VAL_W-1:0] cell_value,
  output      logic [VAL_W-1:0] final_change,
  output      logic [VAL_W-1:0] sweep_count,
  output      logic             converged,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [VAL_W-1:0] cfg_data
);

  localparam int NCELLS = ROWS * COLS;
  localparam int IDX_W = $clog2(NCELLS);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_COPY = 3'd4;
  localparam logic [2:0] ST_CHECK = 3'd5;

  localparam logic [2:0] PH_SELF = 3'd0;
  localparam logic [2:0] PH_E = 3'd1;
  localparam logic [2:0] PH_W = 3'd2;
  localparam logic [2:0] PH_S = 3'd3;
  localparam logic [2:0] PH_N = 3'd4;
  localparam logic [2:0] PH_NEW = 3'd5;
  localparam logic [2:0] PH_DIFF = 3'd6;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NCELLS - 1);
  localparam logic [CNT_W-1:0] NCELLS_C = CNT_W'(NCELLS);
  localparam logic [CNT_W-1:0] COLS_C = CNT_W'(COLS);
  localparam logic [CNT_W-1:0] UP_OFS = CNT_W'(NCELLS - COLS);

  logic [2:0]        state;
  logic [2:0]        phase;
  logic [IDX_W-1:0]  cell_idx;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] self_word;
  logic [SUM_W-1:0]  acc;
  logic [VAL_W-1:0]  newv;
  logic [VAL_W-1:0]  worst;
  logic [VAL_W-1:0]  sweeps;
  logic              rd_in_grid;
  logic [VAL_W-1:0]  epsilon;
  logic [VAL_W-1:0]  max_iter;

  logic              accept;
  logic              in_grid;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  cell_x;
  logic [CNT_W-1:0]  down_sum;
  logic [IDX_W-1:0]  east_idx;
  logic [IDX_W-1:0]  west_idx;
  logic [IDX_W-1:0]  south_idx;
  logic [IDX_W-1:0]  north_idx;
  logic [SUM_W-1:0]  sum_in;
  logic [VAL_W-1:0]  new_val;
  logic [VAL_W-1:0]  diff;
  logic [VAL_W-1:0]  sweeps_inc;
  logic              is_conv;
  logic              solve_done;

  logic              grid_we;
  logic [IDX_W-1:0]  grid_waddr;
  logic [WORD_W-1:0] grid_wdata;
  logic [IDX_W-1:0]  grid_raddr;
  logic [WORD_W-1:0] grid_rdata;
  logic              nxt_we;
  logic [IDX_W-1:0]  nxt_raddr;
  logic [WORD_W-1:0] nxt_rdata;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept = in_valid && in_ready;
  assign in_grid = (32'(row) < 32'(ROWS)) && (32'(col) < 32'(COLS));
  assign idx = IDX_W'(32'(row) * 32'(COLS) + 32'(col));

  // neighbor addresses, wrapped around the flat index
  assign cell_x = {1'b0, cell_idx};
  assign down_sum = cell_x + COLS_C;
  assign east_idx = (cell_idx == LAST_IDX) ? '0 : cell_idx + 1'b1;
  assign west_idx = (cell_idx == '0) ? LAST_IDX : cell_idx - 1'b1;
  assign south_idx = (down_sum >= NCELLS_C) ? IDX_W'(down_sum - NCELLS_C) : IDX_W'(down_sum);
  assign north_idx = (cell_x < COLS_C) ? IDX_W'(cell_x + UP_OFS) : IDX_W'(cell_x - COLS_C);

  // shared accumulate adder and difference unit
  assign sum_in = ((phase == PH_W) ? '0 : acc) + {2'b00, grid_rdata[VAL_W-1:0]};
  assign new_val = self_word[VAL_W] ? self_word[VAL_W-1:0] : sum_in[SUM_W-1:2];
  assign diff = (self_word[VAL_W-1:0] >= newv) ? (self_word[VAL_W-1:0] - newv)
                                               : (newv - self_word[VAL_W-1:0]);

  assign sweeps_inc = (sweeps == COUNT_SAT) ? sweeps : sweeps + 1'b1;
  assign is_conv = worst < epsilon;
  assign solve_done = is_conv || (sweeps_inc >= max_iter);

  always_comb begin
    grid_we = 1'b0;
    grid_waddr = idx;
    grid_wdata = {fixed, temperature};
    grid_raddr = idx;
    case (state)
      ST_CLEAR: begin
        grid_we = 1'b1;
        grid_waddr = cnt[IDX_W-1:0];
        grid_wdata = '0;
      end
      ST_IDLE: begin
        grid_we = accept && (cmd == CMD_WRITE) && in_grid;
      end
      ST_CALC: begin
        case (phase)
          PH_SELF: grid_raddr = cell_idx;
          PH_E: grid_raddr = east_idx;
          PH_W: grid_raddr = west_idx;
          PH_S: grid_raddr = south_idx;
          PH_N: grid_raddr = north_idx;
          default: grid_raddr = cell_idx;
        endcase
      end
      ST_COPY: begin
        grid_we = (cnt != '0);
        grid_waddr = IDX_W'(cnt - 1'b1);
        grid_wdata = nxt_rdata;
      end
      default: begin
        grid_we = 1'b0;
      end
    endcase
  end

  assign nxt_we = (state == ST_CALC) && (phase == PH_NEW);
  assign nxt_raddr = (cnt < NCELLS_C) ? cnt[IDX_W-1:0] : '0;

  jhs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NCELLS)
  ) u_grid (
    .clk  (clk),
    .we   (grid_we),
    .waddr(grid_waddr),
    .wdata(grid_wdata),
    .raddr(grid_raddr),
    .rdata(grid_rdata)
  );

  jhs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NCELLS)
  ) u_next (
    .clk  (clk),
    .we   (nxt_we),
    .waddr(cell_idx),
    .wdata({self_word[VAL_W], new_val}),
    .raddr(nxt_raddr),
    .rdata(nxt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPSILON_RESET;
      max_iter <= MAX_ITER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EPSILON: epsilon <= cfg_data;
        REG_MAX_ITER: max_iter <= cfg_data;
        default: epsilon <= epsilon;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      phase <= PH_SELF;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !accept) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NCELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_SOLVE: begin
                state <= ST_CALC;
                phase <= PH_SELF;
                cell_idx <= '0;
                worst <= '0;
                sweeps <= '0;
                out_valid <= 1'b0;
              end
              CMD_READ: begin
                state <= ST_READ;
                rd_in_grid <= in_grid;
                out_valid <= 1'b0;
              end
              default: begin
                out_valid <= 1'b1;
                cell_value <= '0;
                final_change <= '0;
                sweep_count <= '0;
                converged <= 1'b0;
              end
            endcase
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
          out_valid <= 1'b1;
          cell_value <= rd_in_grid ? grid_rdata[VAL_W-1:0] : '0;
          final_change <= '0;
          sweep_count <= '0;
          converged <= 1'b0;
        end
        ST_CALC: begin
          if (phase != PH_DIFF) begin
            phase <= phase + 1'b1;
          end
          case (phase)
            PH_E: self_word <= grid_rdata;
            PH_W, PH_S, PH_N: acc <= sum_in;
            PH_NEW: newv <= new_val;
            PH_DIFF: begin
              if (diff > worst) begin
                worst <= diff;
              end
              phase <= PH_SELF;
              if (cell_idx == LAST_IDX) begin
                state <= ST_COPY;
                cnt <= '0;
              end else begin
                cell_idx <= cell_idx + 1'b1;
              end
            end
            default: acc <= acc;
          endcase
        end
        ST_COPY: begin
          cnt <= cnt + 1'b1;
          if (cnt == NCELLS_C) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          sweeps <= sweeps_inc;
          if (solve_done) begin
            state <= ST_IDLE;
            out_valid <= 1'b1;
            cell_value <= '0;
            final_change <= worst;
            sweep_count <= sweeps_inc;
            converged <= is_conv;
          end else begin
            state <= ST_CALC;
            phase <= PH_SELF;
            cell_idx <= '0;
            worst <= '0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_grid_frozen_in_calc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) |-> !grid_we)
    else $error("grid written during stencil pass");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) |-> (phase <= PH_DIFF))
    else $error("stencil phase out of range");

  a_conv_below_eps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && converged) |-> (final_change < epsilon))
    else $error("converged reported with change not below epsilon");

  a_limit_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !converged && (sweep_count != '0)) |-> (sweep_count >= max_iter))
    else $error("solve stopped before limit without converging");

  a_read_no_solve_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (cell_value != '0)) |-> ((sweep_count == '0) && !converged))
    else $error("read result carries solve fields");
`endif

endmodule

`default_nettype wire
